>>> sv/olmr_pkg.sv
// Shared types and codes for the ordered list min/max delete and reverse core.
package olmr_pkg;

    localparam int VAL_W   = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_MAX = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_MIN = 3'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // One result beat as it travels from the sequencer to the output register.
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VAL_W-1:0]   item_value;
        logic               last;
        logic [COUNT_W-1:0] count;
    } resp_t;

endpackage

>>> sv/olmr_mem.sv
// Element store: one write port and one read port with registered read data.
module olmr_mem #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [olmr_pkg::VAL_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [olmr_pkg::VAL_W-1:0] rdata
);
    import olmr_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/olmr_obuf.sv
// Output register that holds one result beat until the downstream side takes it.
module olmr_obuf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  olmr_pkg::resp_t         push_data,
    output logic                    ready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [39:0]             m_tdata,
    output logic [olmr_pkg::ST_W-1:0] m_tuser,
    output logic                    m_tlast
);
    import olmr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    resp_t data_reg;

    assign ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, data_reg.count, data_reg.item_value};
    assign m_tuser  = data_reg.status;
    assign m_tlast  = data_reg.last;

endmodule

>>> sv/ordered_list_minmax_delete_reverse_core.sv
// Top level of the ordered list core: sequencer around one element memory.
//
// The core keeps an ordered list of up to DEPTH signed 32-bit values in a
// single memory with one write port and one read port whose read data is
// registered. An item is a command in s_tuser (append, delete max, delete
// min, reverse, dump) with the value to append in s_tdata. The core works on
// one command at a time and takes the next one once the last result beat of
// the current one has been handed to the output register, so a downstream
// stall holds it only while that register is still full. Delete max and
// delete min read the whole list once to find the first occurrence of the
// extreme value and then move every later element down one place. Reverse
// swaps pairs from both ends, one pair at a time, since each swap needs two
// reads and two writes on the single memory port pair. Dump reads each
// element and hands its beat to the output register before reading the next,
// with tlast on the final one; an empty list dumps as a single beat with
// empty status. No element location is ever read in the same cycle it is
// written, so the memory needs no forwarding path. After reset the list is
// empty and the core accepts commands in the next cycle.
module ordered_list_minmax_delete_reverse_core #(
    parameter int DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // [31:0] value
    input  logic [olmr_pkg::OP_W-1:0] s_tuser,   // [2:0] opcode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,   // [31:0] item_value, [36:32] count, zero fill
    output logic [olmr_pkg::ST_W-1:0] m_tuser,   // [1:0] status
    output logic                      m_tlast
);
    import olmr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_RA    = 4'd3;
    localparam logic [3:0] S_RB    = 4'd4;
    localparam logic [3:0] S_WA    = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_DREAD = 4'd8;
    localparam logic [3:0] S_DEMIT = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0] best_reg, best_next;
    logic [VAL_W-1:0] tmp_reg, tmp_next;
    logic             want_max_reg, want_max_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0] item_reg, item_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic             push;
    resp_t            push_data;
    logic             obuf_ready;

    logic             accept;
    logic [AW-1:0]    last_idx;
    logic             better;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign last_idx = AW'(fill_reg - 1'b1);

    // A new candidate wins only when strictly better, so the earliest
    // occurrence of the extreme value is the one removed.
    assign better = want_max_reg ? ($signed(mem_rdata) > $signed(best_reg))
                                 : ($signed(mem_rdata) < $signed(best_reg));

    olmr_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    olmr_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .ready     (obuf_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        busy_next     = busy_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        tmp_next      = tmp_reg;
        want_max_next = want_max_reg;
        status_next   = status_reg;
        item_next     = item_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        push          = 1'b0;
        push_data     = '{status: status_reg, item_value: item_reg, last: 1'b1,
                          count: COUNT_W'(fill_reg)};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    item_next   = '0;
                    state_next  = S_EMIT;
                    unique case (s_tuser) inside
                        OP_APPEND: begin
                            if (fill_reg >= CW'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = s_tdata;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_DEL_MAX, OP_DEL_MIN: begin
                            if (fill_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                want_max_next = (s_tuser == OP_DEL_MAX);
                                rd_ptr_next   = '0;
                                busy_next     = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_REVERSE: begin
                            if (fill_reg > CW'(1)) begin
                                rd_ptr_next = '0;
                                wr_ptr_next = last_idx;
                                state_next  = S_RA;
                            end
                        end
                        OP_DUMP: begin
                            if (fill_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_ptr_next = '0;
                                state_next  = S_DREAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (busy_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_ptr_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg;
                    if (rd_ptr_reg == last_idx) begin
                        busy_next = 1'b0;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
                if (pend_reg && ((pend_idx_reg == '0) || better)) begin
                    best_next = mem_rdata;
                    pos_next  = pend_idx_reg;
                end
                if (!busy_reg && !pend_reg) begin
                    wr_ptr_next = pos_reg;
                    if ((CW'(pos_reg) + 1'b1) < fill_reg) begin
                        rd_ptr_next = pos_reg + 1'b1;
                        busy_next   = 1'b1;
                        state_next  = S_SHIFT;
                    end else begin
                        fill_next   = fill_reg - 1'b1;
                        status_next = ST_OK;
                        item_next   = best_reg;
                        state_next  = S_EMIT;
                    end
                end
            end

            S_SHIFT: begin
                // Reads run ahead of writes, so they never meet.
                if (busy_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_ptr_reg;
                    pend_next = 1'b1;
                    if (rd_ptr_reg == last_idx) begin
                        busy_next = 1'b0;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
                if (pend_reg) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_ptr_reg;
                    mem_wdata   = mem_rdata;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (!busy_reg && !pend_reg) begin
                    fill_next   = fill_reg - 1'b1;
                    status_next = ST_OK;
                    item_next   = best_reg;
                    state_next  = S_EMIT;
                end
            end

            S_RA: begin
                mem_re     = 1'b1;
                mem_raddr  = rd_ptr_reg;
                state_next = S_RB;
            end

            S_RB: begin
                mem_re     = 1'b1;
                mem_raddr  = wr_ptr_reg;
                tmp_next   = mem_rdata;
                state_next = S_WA;
            end

            S_WA: begin
                mem_we     = 1'b1;
                mem_waddr  = rd_ptr_reg;
                mem_wdata  = mem_rdata;
                state_next = S_WB;
            end

            S_WB: begin
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                mem_wdata = tmp_reg;
                if ((rd_ptr_reg + 1'b1) < (wr_ptr_reg - 1'b1)) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    wr_ptr_next = wr_ptr_reg - 1'b1;
                    state_next  = S_RA;
                end else begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT: begin
                if (obuf_ready) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DREAD: begin
                mem_re     = 1'b1;
                mem_raddr  = rd_ptr_reg;
                state_next = S_DEMIT;
            end

            S_DEMIT: begin
                push_data = '{status: ST_OK, item_value: mem_rdata,
                              last: (rd_ptr_reg == last_idx),
                              count: COUNT_W'(fill_reg)};
                if (obuf_ready) begin
                    push = 1'b1;
                    if (rd_ptr_reg == last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                        state_next  = S_DREAD;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        best_reg     <= best_next;
        tmp_reg      <= tmp_next;
        want_max_reg <= want_max_next;
        status_reg   <= status_next;
        item_reg     <= item_next;
    end

endmodule

>>> sv/olmr_checker.sv
// Port-level checks for the ordered list core, bound to its top level.
module olmr_checker #(
    parameter int DEPTH = 16
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [39:0]               m_tdata,
    input logic [olmr_pkg::ST_W-1:0] m_tuser,
    input logic                      m_tlast
);
    import olmr_pkg::*;

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The output register comes out of reset empty.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present right after reset");

    // A rejected append reports a full list.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |->
            (m_tdata[36:32] == COUNT_W'(DEPTH)) && m_tlast && (m_tdata[31:0] == '0))
        else $error("full status with wrong count or payload");

    // An empty status always carries a zero count and ends the command.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |->
            (m_tdata[36:32] == '0) && m_tlast && (m_tdata[31:0] == '0))
        else $error("empty status with wrong count or payload");

    // The count never exceeds the list capacity; the check is skipped when DEPTH is above 31.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 31) || (m_tdata[36:32] <= COUNT_W'(DEPTH)))
        else $error("count above capacity");

endmodule

bind ordered_list_minmax_delete_reverse_core olmr_checker #(.DEPTH(DEPTH)) u_olmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> test/ordered_list_minmax_delete_reverse_core_tb.sv
// Self-checking testbench for the ordered list min/max delete and reverse core.
module ordered_list_minmax_delete_reverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olmr_pkg::*;

    localparam int DEPTH      = 16;
    localparam int N_RANDOM   = 350;
    // Input beats accepted before the result side goes quiet for a long stretch.
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 400;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int IDLE_LIMIT = 4000;
    // Quiet cycles at the end so that any stray beat still shows up.
    localparam int TAIL_WAIT  = 60;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        bit               drain;   // hold the input until every result is back
    } command_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [ST_W-1:0]     m_tuser;
    logic                m_tlast;

    command_t            pending_cmds[$];
    resp_t               expected_beats[$];

    // Shadow copy of the list, kept in step with every accepted command.
    logic signed [VAL_W-1:0] list_vals[DEPTH] = '{default: '0};
    int                  list_fill = 0;

    int                  items_accepted = 0;
    int                  beats_seen = 0;
    int                  errors = 0;
    int                  op_count[8] = '{default: 0};
    int                  full_rejects = 0;
    int                  empty_hits = 0;
    bit                  idle_off;

    int                  send_gap = 0;
    logic                valid_nxt;
    command_t            cmd;

    int                  ready_gap = 0;
    int                  hold_left = 0;
    bit                  long_hold_done = 1'b0;
    logic                ready_nxt;

    resp_t               exp_beat;

    ordered_list_minmax_delete_reverse_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Neither side inserts random gaps while this window of input beats goes by.
    assign idle_off = (items_accepted >= 220) && (items_accepted < 280);

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mode 0 fills the list, mode 1 empties it, mode 2 mixes everything with
    // small values so that equal extremes are common.
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 75) return OP_APPEND;
                if (r < 82) return OP_DEL_MAX;
                if (r < 89) return OP_DEL_MIN;
                if (r < 94) return OP_REVERSE;
                return OP_DUMP;
            end
            1: begin
                if (r < 20) return OP_APPEND;
                if (r < 50) return OP_DEL_MAX;
                if (r < 80) return OP_DEL_MIN;
                if (r < 90) return OP_REVERSE;
                return OP_DUMP;
            end
            default: begin
                if (r < 40) return OP_APPEND;
                if (r < 55) return OP_DEL_MAX;
                if (r < 70) return OP_DEL_MIN;
                if (r < 85) return OP_REVERSE;
                return OP_DUMP;
            end
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'h8000_0000;
        if (r < 16) return 32'h7FFF_FFFF;
        if (r < ((mode == 2) ? 90 : 40)) return VAL_W'($urandom_range(0, 6) - 3);
        return $urandom;
    endfunction

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        pending_cmds.push_back('{op: op, value: value, drain: 1'b0});
    endtask

    task automatic push_drain();
        pending_cmds.push_back('{op: OP_APPEND, value: '0, drain: 1'b1});
    endtask

    task automatic queue_beat(input logic [ST_W-1:0] status, input logic [VAL_W-1:0] value,
                              input logic last);
        expected_beats.push_back('{status: status, item_value: value, last: last,
                                   count: COUNT_W'(list_fill)});
        if (status == ST_FULL) full_rejects++;
        if (status == ST_EMPTY) empty_hits++;
    endtask

    // Applies one accepted command to the shadow list and queues the result
    // beats the core has to return for it.
    task automatic predict_command(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        int pos;
        logic signed [VAL_W-1:0] best;
        logic signed [VAL_W-1:0] tmp;
        bit is_max;
        op_count[op]++;
        case (op)
            OP_APPEND: begin
                if (list_fill >= DEPTH) begin
                    queue_beat(ST_FULL, '0, 1'b1);
                end else begin
                    list_vals[list_fill] = value;
                    list_fill++;
                    queue_beat(ST_OK, '0, 1'b1);
                end
            end
            OP_DEL_MAX, OP_DEL_MIN: begin
                if (list_fill == 0) begin
                    queue_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    // Strict compare keeps the earliest of several equal extremes.
                    is_max = (op == OP_DEL_MAX);
                    pos = 0;
                    best = list_vals[0];
                    for (int i = 1; i < list_fill; i++) begin
                        if (is_max ? (list_vals[i] > best) : (list_vals[i] < best)) begin
                            best = list_vals[i];
                            pos = i;
                        end
                    end
                    for (int i = pos; i < list_fill - 1; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_fill--;
                    queue_beat(ST_OK, best, 1'b1);
                end
            end
            OP_REVERSE: begin
                for (int i = 0; i < list_fill / 2; i++) begin
                    tmp = list_vals[i];
                    list_vals[i] = list_vals[list_fill - 1 - i];
                    list_vals[list_fill - 1 - i] = tmp;
                end
                queue_beat(ST_OK, '0, 1'b1);
            end
            OP_DUMP: begin
                if (list_fill == 0) begin
                    queue_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_fill; i++)
                        queue_beat(ST_OK, list_vals[i], (i == list_fill - 1));
                end
            end
            default: begin
                // Undefined commands leave the list alone and answer with one beat.
                queue_beat(ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_field(input string name, input logic [39:0] want,
                                input logic [39:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    // Command driver: takes commands off the pending queue, holds each one
    // until the core accepts it, and feeds every accepted beat to the predictor.
    always @(posedge aclk) begin : drive
        if (aresetn) begin
            valid_nxt = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_command(s_tuser, s_tdata);
                items_accepted++;
                valid_nxt = 1'b0;
                send_gap = idle_off ? 0 : pick_gap();
            end
            if (!valid_nxt) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_cmds.size() > 0) begin
                    if (pending_cmds[0].drain) begin
                        // Pause until every result of earlier commands is back.
                        if (expected_beats.size() == 0)
                            void'(pending_cmds.pop_front());
                    end else begin
                        cmd = pending_cmds.pop_front();
                        valid_nxt = 1'b1;
                        s_tdata <= cmd.value;
                        s_tuser <= cmd.op;
                    end
                end
            end
            s_tvalid <= valid_nxt;
        end
    end

    // Result-side backpressure, including one long hold-off that lets the core
    // fill its output register and stall the command input. The hold starts only
    // while the next commands are real ones, so the sender keeps offering beats.
    always @(posedge aclk) begin : accept_results
        if (aresetn) begin
            if (m_tvalid && m_tready)
                ready_gap = idle_off ? 0 : pick_gap();
            if (!long_hold_done && items_accepted >= HOLD_AT && pending_cmds.size() > 1
                    && !pending_cmds[0].drain && !pending_cmds[1].drain) begin
                hold_left = HOLD_LEN;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            m_tready <= ready_nxt;
        end
    end

    // Result checker: each beat is compared field by field with the oldest
    // expected beat.
    always @(posedge aclk) begin : check_results
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result beat, status %0d data %0h last %b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                exp_beat = expected_beats.pop_front();
                if (m_tuser !== exp_beat.status)
                    report_field("status", 40'(exp_beat.status), 40'(m_tuser));
                if (m_tdata[31:0] !== exp_beat.item_value)
                    report_field("item_value", 40'(exp_beat.item_value), 40'(m_tdata[31:0]));
                if (m_tdata[36:32] !== exp_beat.count)
                    report_field("count", 40'(exp_beat.count), 40'(m_tdata[36:32]));
                if (m_tlast !== exp_beat.last)
                    report_field("last", 40'(exp_beat.last), 40'(m_tlast));
                if (m_tdata[39:37] !== 3'b000)
                    report_field("tdata padding", 40'd0, 40'(m_tdata[39:37]));
            end
        end
    end

    // Watchdog: ends the run when neither side moves a beat for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_beats.size());
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int mode;
        int run_len;
        int n_rand;

        // Directed part: empty list corner cases first.
        push_cmd(OP_DUMP, 32'h0);
        push_cmd(OP_DEL_MAX, 32'hFFFF_FFFF);
        push_cmd(OP_DEL_MIN, 32'h0);
        push_cmd(OP_REVERSE, 32'h0);
        // A single element reverses to itself.
        push_cmd(OP_APPEND, 32'd5);
        push_cmd(OP_REVERSE, 32'h0);
        // Both signed extremes, with a repeated maximum and a repeated minimum.
        push_cmd(OP_APPEND, 32'h7FFF_FFFF);
        push_cmd(OP_APPEND, 32'h8000_0000);
        push_cmd(OP_APPEND, 32'hFFFF_FFFF);
        push_cmd(OP_APPEND, 32'h0);
        push_cmd(OP_APPEND, 32'h7FFF_FFFF);
        push_cmd(OP_APPEND, 32'h8000_0000);
        push_cmd(OP_DUMP, 32'h0);
        push_cmd(OP_DEL_MAX, 32'h0);
        push_cmd(OP_DEL_MIN, 32'h0);
        push_cmd(OP_REVERSE, 32'h0);
        push_cmd(OP_DUMP, 32'h0);
        // Undefined commands are answered but change nothing.
        push_cmd(3'd5, 32'h1234_5678);
        push_cmd(3'd6, 32'hFFFF_FFFF);
        push_cmd(3'd7, 32'h0);
        push_cmd(OP_DUMP, 32'h0);
        push_drain();

        // Random part: runs of commands in one of three flavors, with a pause
        // for all results now and then.
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            mode = $urandom_range(0, 2);
            run_len = $urandom_range(8, 40);
            for (int i = 0; i < run_len && n_rand < N_RANDOM; i++) begin
                push_cmd(pick_op(mode), pick_value(mode));
                n_rand++;
            end
            if ($urandom_range(0, 3) == 0)
                push_drain();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_cmds.size() == 0 && s_tvalid == 1'b0);
        wait (expected_beats.size() == 0);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Covered %0d commands: append %0d, delete max %0d, delete min %0d, reverse %0d,",
                 items_accepted, op_count[OP_APPEND], op_count[OP_DEL_MAX],
                 op_count[OP_DEL_MIN], op_count[OP_REVERSE]);
        $display("dump %0d, undefined %0d; %0d result beats, %0d full rejects, %0d empty hits",
                 op_count[OP_DUMP], op_count[5] + op_count[6] + op_count[7], beats_seen,
                 full_rejects, empty_hits);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
